### rtl/hplc_pkg.sv
// ----------------------------------------------------------------------------
// hplc_pkg
// shared types, event codes and character classes for the line command parser
// ----------------------------------------------------------------------------
package hplc_pkg;

    localparam int LINE_PIXELS = 96;

    localparam int CHAR_W      = 8;
    localparam int LINE_W      = 16;
    localparam int OFF_W       = 16;
    localparam int PIX_IDX_W   = 7;
    localparam int COLOR_W     = 16;
    localparam int KIND_W      = 2;
    localparam int OUT_TDATA_W = 48;

    localparam logic [KIND_W-1:0] EV_PIXEL  = 2'd0;
    localparam logic [KIND_W-1:0] EV_START  = 2'd1;
    localparam logic [KIND_W-1:0] EV_END    = 2'd2;
    localparam logic [KIND_W-1:0] EV_RENDER = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [LINE_W-1:0]    line_index;
        logic [PIX_IDX_W-1:0] pixel_index;
        logic [COLOR_W-1:0]   pixel_color;
        logic                 run_end;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } step_t;

    function automatic logic is_ws(input logic [CHAR_W-1:0] c);
        return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic [3:0] hex_value(input logic [CHAR_W-1:0] c);
        logic [3:0] v;
        v = 4'd0;
        if ((c >= 8'h30) && (c <= 8'h39)) begin
            v = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            v = 4'(c[2:0] + 3'd1) + 4'd8;
        end
        return v;
    endfunction

    function automatic logic [CHAR_W-1:0] start_char(input logic [2:0] pos);
        logic [CHAR_W-1:0] ch;
        case (pos)
            3'd0: ch = 8'h53;
            3'd1: ch = 8'h54;
            3'd2: ch = 8'h41;
            3'd3: ch = 8'h52;
            3'd4: ch = 8'h54;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [CHAR_W-1:0] end_char(input logic [2:0] pos);
        logic [CHAR_W-1:0] ch;
        case (pos)
            3'd0: ch = 8'h45;
            3'd1: ch = 8'h4E;
            3'd2: ch = 8'h44;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

### rtl/hplc_parser.sv
// ----------------------------------------------------------------------------
// hplc_parser
// per character parse state and the events one character causes
// ----------------------------------------------------------------------------
module hplc_parser
    import hplc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  logic [CHAR_W-1:0] char_in,
    input  logic              is_final,
    output step_t             step_out
);

    localparam logic [3:0] PH_WORD   = 4'd0;
    localparam logic [3:0] PH_WSP    = 4'd1;
    localparam logic [3:0] PH_KSTART = 4'd2;
    localparam logic [3:0] PH_KEND   = 4'd3;
    localparam logic [3:0] PH_LINESP = 4'd4;
    localparam logic [3:0] PH_LINE   = 4'd5;
    localparam logic [3:0] PH_OFFSP  = 4'd6;
    localparam logic [3:0] PH_OFF    = 4'd7;
    localparam logic [3:0] PH_HEXSP  = 4'd8;
    localparam logic [3:0] PH_HEX    = 4'd9;
    localparam logic [3:0] PH_IGNORE = 4'd10;

    localparam logic [OFF_W-1:0] LINE_LIMIT = OFF_W'(LINE_PIXELS);

    logic [3:0]        phase_reg,  phase_next;
    logic [2:0]        kpos_reg,   kpos_next;
    logic [LINE_W-1:0] line_reg,   line_next;
    logic [OFF_W-1:0]  offset_reg, offset_next;
    logic [11:0]       accum_reg,  accum_next;
    logic [1:0]        nib_reg,    nib_next;

    logic              ws;
    logic              dig;
    logic [3:0]        digit;
    logic [3:0]        nib_val;
    logic              do_hex;
    logic              ev_valid;
    logic [KIND_W-1:0] ev_kind;
    logic              render;
    result_t           prim;
    result_t           rend;

    assign ws      = is_ws(char_in);
    assign dig     = is_digit(char_in);
    assign digit   = char_in[3:0];
    assign nib_val = hex_value(char_in);

    always_comb begin
        phase_next  = phase_reg;
        kpos_next   = kpos_reg;
        line_next   = line_reg;
        offset_next = offset_reg;
        accum_next  = accum_reg;
        nib_next    = nib_reg;
        do_hex      = 1'b0;
        ev_valid    = 1'b0;
        ev_kind     = EV_PIXEL;
        unique case (phase_reg)
            PH_WORD: begin
                if (ws) begin
                    phase_next = PH_WSP;
                end
            end
            PH_WSP: begin
                if (!ws) begin
                    if (char_in == start_char(3'd0)) begin
                        phase_next = PH_KSTART;
                        kpos_next  = 3'd1;
                    end else if (char_in == end_char(3'd0)) begin
                        phase_next = PH_KEND;
                        kpos_next  = 3'd1;
                    end else if (char_in == 8'h43) begin
                        phase_next = PH_LINESP;
                    end else begin
                        phase_next = PH_IGNORE;
                    end
                end
            end
            PH_KSTART: begin
                if (kpos_reg < 3'd5 && char_in == start_char(kpos_reg)) begin
                    kpos_next = kpos_reg + 3'd1;
                    if (kpos_reg == 3'd4) begin
                        ev_valid   = 1'b1;
                        ev_kind    = EV_START;
                        phase_next = PH_IGNORE;
                    end
                end else begin
                    phase_next = PH_IGNORE;
                end
            end
            PH_KEND: begin
                if (kpos_reg < 3'd3 && char_in == end_char(kpos_reg)) begin
                    kpos_next = kpos_reg + 3'd1;
                    if (kpos_reg == 3'd2) begin
                        ev_valid   = 1'b1;
                        ev_kind    = EV_END;
                        phase_next = PH_IGNORE;
                    end
                end else begin
                    phase_next = PH_IGNORE;
                end
            end
            PH_LINESP, PH_LINE: begin
                if (dig) begin
                    phase_next = PH_LINE;
                    line_next  = (line_reg << 3) + (line_reg << 1) + LINE_W'(digit);
                end else if (ws) begin
                    phase_next = (phase_reg == PH_LINE) ? PH_OFFSP : PH_LINESP;
                end else begin
                    do_hex = 1'b1;
                end
            end
            PH_OFFSP, PH_OFF: begin
                if (dig) begin
                    phase_next  = PH_OFF;
                    offset_next = (offset_reg << 3) + (offset_reg << 1) + OFF_W'(digit);
                end else if (ws) begin
                    phase_next = (phase_reg == PH_OFF) ? PH_HEXSP : PH_OFFSP;
                end else begin
                    do_hex = 1'b1;
                end
            end
            PH_HEXSP: begin
                if (!ws) begin
                    do_hex = 1'b1;
                end
            end
            PH_HEX: begin
                do_hex = 1'b1;
            end
            default: begin
            end
        endcase

        if (do_hex) begin
            phase_next = PH_HEX;
            if (offset_reg < LINE_LIMIT) begin
                if (nib_reg != 2'd3) begin
                    accum_next = {accum_reg[7:0], nib_val};
                    nib_next   = nib_reg + 2'd1;
                end else begin
                    ev_valid    = 1'b1;
                    ev_kind     = EV_PIXEL;
                    offset_next = offset_reg + OFF_W'(1);
                    accum_next  = 12'd0;
                    nib_next    = 2'd0;
                end
            end
        end

        render = is_final && (phase_next >= PH_LINESP) && (phase_next <= PH_HEX) &&
                 (offset_next >= LINE_LIMIT);
    end

    always_comb begin
        prim.kind        = ev_kind;
        prim.line_index  = '0;
        prim.pixel_index = (ev_kind == EV_PIXEL) ? offset_reg[PIX_IDX_W-1:0] : '0;
        prim.pixel_color = (ev_kind == EV_PIXEL) ? {accum_reg, nib_val} : '0;
        prim.run_end     = !render;

        rend.kind        = EV_RENDER;
        rend.line_index  = line_next;
        rend.pixel_index = '0;
        rend.pixel_color = '0;
        rend.run_end     = 1'b1;

        step_out.count  = 2'(ev_valid) + 2'(render);
        step_out.first  = ev_valid ? prim : rend;
        step_out.second = rend;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_WORD;
            kpos_reg   <= 3'd0;
            line_reg   <= '0;
            offset_reg <= '0;
            accum_reg  <= '0;
            nib_reg    <= 2'd0;
        end else if (step_en) begin
            if (is_final) begin
                phase_reg  <= PH_WORD;
                kpos_reg   <= 3'd0;
                line_reg   <= '0;
                offset_reg <= '0;
                accum_reg  <= '0;
                nib_reg    <= 2'd0;
            end else begin
                phase_reg  <= phase_next;
                kpos_reg   <= kpos_next;
                line_reg   <= line_next;
                offset_reg <= offset_next;
                accum_reg  <= accum_next;
                nib_reg    <= nib_next;
            end
        end
    end

    a_final_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && is_final |=> phase_reg == PH_WORD && offset_reg == '0 && nib_reg == 2'd0)
        else $error("parse state not cleared after final word");

    a_pixel_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && step_out.count != 2'd0 && step_out.first.kind == EV_PIXEL
        |-> offset_reg < LINE_LIMIT)
        else $error("pixel write past line width");

    a_two_needs_render: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && step_out.count == 2'd2 |-> is_final && step_out.second.kind == EV_RENDER)
        else $error("two events without render line");

endmodule

### rtl/hplc_out_buf.sv
// ----------------------------------------------------------------------------
// hplc_out_buf
// three word result buffer taking up to two results per cycle while room2 is set
// ----------------------------------------------------------------------------
module hplc_out_buf
    import hplc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic [1:0] push_cnt,
    input  result_t push_first,
    input  result_t push_second,
    input  logic    pop,
    output result_t head,
    output logic    head_valid,
    output logic    room2
);

    logic [1:0] count_reg, count_next;
    result_t    slot_reg [3];
    result_t    slot_next [3];
    logic [1:0] base;
    logic [2:0] src;
    logic [2:0] rel;

    assign base       = count_reg - 2'(pop);
    assign count_next = base + push_cnt;
    assign head       = slot_reg[0];
    assign head_valid = count_reg != 2'd0;
    assign room2      = count_reg <= 2'd1;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            src          = 3'(i) + 3'(pop);
            rel          = 3'(i) - 3'(base);
            slot_next[i] = slot_reg[i];
            if (src < 3'(count_reg)) begin
                slot_next[i] = (src[1:0] == 2'd0) ? slot_reg[0] :
                               (src[1:0] == 2'd1) ? slot_reg[1] : slot_reg[2];
            end else if (rel == 3'd0 && push_cnt != 2'd0) begin
                slot_next[i] = push_first;
            end else if (rel == 3'd1 && push_cnt == 2'd2) begin
                slot_next[i] = push_second;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            slot_reg[i] <= slot_next[i];
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_cnt == 2'd2 |-> room2)
        else $error("result buffer overflow");

    a_render_last: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid && head.kind == EV_RENDER |-> head.run_end)
        else $error("render line not last of run");

    a_clean_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid && head.kind != EV_PIXEL |-> head.pixel_color == '0 && head.pixel_index == '0)
        else $error("pixel fields set on non pixel event");

endmodule

### rtl/hex_pixel_line_command_parse_top.sv
// ----------------------------------------------------------------------------
// hex_pixel_line_command_parse_top
// streams command text characters in and pixel, image and render events out
// ----------------------------------------------------------------------------
// path: a character accepted on s_axis is held in the input register, and its
//   results are written into the result buffer, whose head drives m_axis
// throughput: one character per cycle while the result buffer holds at most one
//   word; else s_axis_tready stalls while the buffer drains back to one word
// reset: aresetn synchronous active low clears the parse state, the input
//   register valid and the result buffer count
// ----------------------------------------------------------------------------
module hex_pixel_line_command_parse_top
    import hplc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [CHAR_W-1:0]      s_axis_tdata,  // [7:0] char_in
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [1:0] event_kind, [17:2] line_index, [24:18] pixel_index, [40:25] pixel_color
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast
);

    logic              in_vld_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_final_reg;
    logic              consume;
    logic              room2;
    logic              pop;
    step_t             step;
    result_t           head;
    logic [1:0]        push_cnt;

    assign consume       = in_vld_reg && room2;
    assign s_axis_tready = !in_vld_reg || consume;
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign push_cnt      = consume ? step.count : 2'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_char_reg  <= s_axis_tdata;
            in_final_reg <= s_axis_tlast;
        end
    end

    hplc_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (consume),
        .char_in  (in_char_reg),
        .is_final (in_final_reg),
        .step_out (step)
    );

    hplc_out_buf u_out_buf (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push_cnt    (push_cnt),
        .push_first  (step.first),
        .push_second (step.second),
        .pop         (pop),
        .head        (head),
        .head_valid  (m_axis_tvalid),
        .room2       (room2)
    );

    assign m_axis_tdata = {7'd0, head.pixel_color, head.pixel_index, head.line_index,
                           head.kind};
    assign m_axis_tlast = head.run_end;

endmodule
